// ===== hw/rtl/obe_pkg.sv =====
package obe_pkg;

	localparam int KIND_W    = 3;
	localparam int INDEX_W   = 32;
	localparam int OFFSET_W  = 31;
	localparam int LENGTH_W  = 12;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 31;

	typedef enum logic [KIND_W-1:0] {
		KIND_SET       = 3'd0,
		KIND_CLEAR     = 3'd1,
		KIND_TEST      = 3'd2,
		KIND_RANGE     = 3'd3,
		KIND_FIND      = 3'd4,
		KIND_CLEAR_ALL = 3'd5,
		KIND_FLIP      = 3'd6,
		KIND_EMPTY     = 3'd7
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OFFSET = 1'b0,
		CFG_LENGTH = 1'b1
	} cfg_reg_t;

endpackage

// ===== hw/rtl/obe_if.sv =====
interface obe_req_if;
	logic                                valid;
	logic                                ready;
	obe_pkg::kind_t                      kind;
	logic signed [obe_pkg::INDEX_W-1:0]  index;
	logic signed [obe_pkg::INDEX_W-1:0]  last_index;

	modport source (output valid, output kind, output index, output last_index, input ready);
	modport sink   (input valid, input kind, input index, input last_index, output ready);
endinterface

interface obe_rsp_if;
	logic                            valid;
	logic                            ready;
	logic                            flag;
	logic [obe_pkg::OFFSET_W-1:0]    found_index;
	logic                            status;

	modport source (output valid, output flag, output found_index, output status, input ready);
	modport sink   (input valid, input flag, input found_index, input status, output ready);
endinterface

// ===== hw/rtl/obe_store.sv =====
module obe_store #(
	parameter int WORD_BITS = 64,
	parameter int DEPTH     = 64,
	parameter int AW        = 6
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [WORD_BITS-1:0] wdata,
	input  logic [AW-1:0]        raddr,
	output logic [WORD_BITS-1:0] rdata
);

	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/offset_bitset_engine.sv =====
// Single-bit set, clear and test each read one store word; range set, complement, empty
// test and find-next walk the store word by word, and a find-next that finds a bit takes
// one step more to form the found index; clear all sweeps the whole store; a request turned
// away before the walk skips it. One transaction is handled at a time: the next request is
// taken only after the result has been loaded into the output register.
// After reset the store is swept to zero with the request channel not ready; configuration
// writes are taken throughout.
module offset_bitset_engine #(
	parameter int WORD_BITS = 64,
	parameter int SET_BITS  = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [obe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [obe_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	obe_req_if.sink                          req,
	obe_rsp_if.source                        rsp
);

	localparam int NW = (SET_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW = (NW > 1) ? $clog2(NW) : 1;
	localparam int BW = $clog2(WORD_BITS);
	localparam int RW = $clog2(SET_BITS);
	localparam int PW = AW + BW;
	localparam int OW = obe_pkg::OFFSET_W;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_CLR  = 6'b000010,
		S_CHK  = 6'b000100,
		S_LOOP = 6'b001000,
		S_ADD  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t state_q;

	logic [OW-1:0]                   range_offset_q;
	logic [obe_pkg::LENGTH_W-1:0]    range_length_q;

	obe_pkg::kind_t                  kind_q;
	logic signed [31:0]              idx_q;
	logic signed [31:0]              last_q;
	logic signed [32:0]              rel_q;
	logic signed [32:0]              sec_q;

	logic [AW-1:0]                   clr_ptr_q;
	logic                            clr_op_q;
	logic [AW-1:0]                   rd_ptr_q;
	logic                            rd_more_q;
	logic                            rd_vld_s1;
	logic [AW-1:0]                   ex_ptr_s1;
	logic [AW-1:0]                   wfirst_q;
	logic [AW-1:0]                   wlast_q;
	logic [BW-1:0]                   lo_q;
	logic [BW-1:0]                   hi_q;
	logic [PW-1:0]                   pos_q;

	logic                            res_flag_q;
	logic [OW-1:0]                   res_found_q;
	logic                            res_status_q;
	logic                            rsp_valid_q;
	logic                            out_flag_q;
	logic [OW-1:0]                   out_found_q;
	logic                            out_status_q;

	logic [RW-1:0]                   len_eff;
	logic signed [32:0]              len33;
	logic [AW-1:0]                   len_word;
	logic [BW-1:0]                   len_bit;

	logic                            rel_out;
	logic                            sec_out;
	logic                            range_skip;
	logic [AW-1:0]                   rel_word;
	logic [AW-1:0]                   sec_word;

	logic [WORD_BITS-1:0]            rdata;
	logic [WORD_BITS-1:0]            lo_mask;
	logic [WORD_BITS-1:0]            hi_mask;
	logic [WORD_BITS-1:0]            sel_mask;
	logic [WORD_BITS-1:0]            hit_bits;
	logic                            hit;
	logic [BW-1:0]                   enc;
	logic [WORD_BITS-1:0]            new_word;
	logic                            loop_wr;
	logic                            ex_last;
	logic                            rsp_load;

	logic                            mem_we;
	logic [AW-1:0]                   mem_waddr;
	logic [WORD_BITS-1:0]            mem_wdata;

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.flag = out_flag_q;
	assign rsp.found_index = out_found_q;
	assign rsp.status = out_status_q;

	// A length beyond the store is clamped to the last bit of the store.
	assign len_eff = (32'(range_length_q) > 32'(SET_BITS - 1)) ? RW'(SET_BITS - 1)
		: RW'(range_length_q);
	assign len33 = 33'(len_eff);
	assign len_word = AW'(len_eff >> BW);
	assign len_bit = len_eff[BW-1:0];

	assign rel_out = (rel_q < 0) || (rel_q > len33);
	assign sec_out = (sec_q < 0) || (sec_q > len33);
	assign range_skip = (idx_q > last_q) || idx_q[31];
	assign rel_word = AW'(rel_q >> BW);
	assign sec_word = AW'(sec_q >> BW);

	// Word walk datapath: the mask keeps the bits of the current word that lie inside
	// the requested window.
	assign lo_mask = {WORD_BITS{1'b1}} << lo_q;
	assign hi_mask = {WORD_BITS{1'b1}} >> (~hi_q);
	assign sel_mask = ((ex_ptr_s1 == wfirst_q) ? lo_mask : {WORD_BITS{1'b1}})
		& ((ex_ptr_s1 == wlast_q) ? hi_mask : {WORD_BITS{1'b1}});
	assign hit_bits = rdata & sel_mask;
	assign hit = |hit_bits;
	assign ex_last = (ex_ptr_s1 == wlast_q);

	always_comb begin
		enc = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (hit_bits[i]) begin
				enc = BW'(i);
			end
		end
	end

	always_comb begin
		new_word = rdata;
		loop_wr = 1'b0;
		case (kind_q) inside
			obe_pkg::KIND_SET, obe_pkg::KIND_RANGE: begin
				new_word = rdata | sel_mask;
				loop_wr = 1'b1;
			end
			obe_pkg::KIND_CLEAR: begin
				new_word = rdata & ~sel_mask;
				loop_wr = 1'b1;
			end
			obe_pkg::KIND_FLIP: begin
				new_word = rdata ^ sel_mask;
				loop_wr = 1'b1;
			end
			default: begin
				new_word = rdata;
				loop_wr = 1'b0;
			end
		endcase
	end

	assign mem_we = (state_q == S_CLR) || ((state_q == S_LOOP) && rd_vld_s1 && loop_wr);
	assign mem_waddr = (state_q == S_CLR) ? clr_ptr_q : ex_ptr_s1;
	assign mem_wdata = (state_q == S_CLR) ? '0 : new_word;
	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	obe_store #(
		.WORD_BITS (WORD_BITS),
		.DEPTH     (NW),
		.AW        (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (rd_ptr_q),
		.rdata (rdata)
	);

	// Control path.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_ptr_q <= '0;
			clr_op_q <= 1'b0;
			rd_more_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
			range_offset_q <= '0;
			range_length_q <= '1;
		end else begin
			if (cfg_we) begin
				unique case (obe_pkg::cfg_reg_t'(cfg_index))
					obe_pkg::CFG_OFFSET: range_offset_q <= cfg_wdata;
					obe_pkg::CFG_LENGTH: range_length_q <= cfg_wdata[obe_pkg::LENGTH_W-1:0];
					default: ;
				endcase
			end

			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_CHK;
					end
				end
				S_CLR: begin
					clr_ptr_q <= clr_ptr_q + 1'b1;
					if (clr_ptr_q == AW'(NW - 1)) begin
						state_q <= clr_op_q ? S_DONE : S_IDLE;
					end
				end
				S_CHK: begin
					rd_vld_s1 <= 1'b0;
					rd_more_q <= 1'b1;
					unique case (kind_q) inside
						obe_pkg::KIND_SET, obe_pkg::KIND_CLEAR, obe_pkg::KIND_TEST: begin
							state_q <= rel_out ? S_DONE : S_LOOP;
						end
						obe_pkg::KIND_RANGE: begin
							state_q <= (range_skip || rel_q < 0 || sec_q > len33) ? S_DONE
								: S_LOOP;
						end
						obe_pkg::KIND_FIND: begin
							state_q <= sec_out ? S_DONE : S_LOOP;
						end
						obe_pkg::KIND_CLEAR_ALL: begin
							clr_ptr_q <= '0;
							clr_op_q <= 1'b1;
							state_q <= S_CLR;
						end
						obe_pkg::KIND_FLIP, obe_pkg::KIND_EMPTY: begin
							state_q <= S_LOOP;
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_LOOP: begin
					rd_vld_s1 <= rd_more_q;
					if (rd_more_q && rd_ptr_q == wlast_q) begin
						rd_more_q <= 1'b0;
					end
					if (rd_vld_s1) begin
						if (kind_q == obe_pkg::KIND_FIND && hit) begin
							state_q <= S_ADD;
						end else if ((kind_q == obe_pkg::KIND_EMPTY && hit) || ex_last) begin
							state_q <= S_DONE;
						end
					end
				end
				S_ADD: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
						clr_op_q <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			kind_q <= req.kind;
			idx_q <= req.index;
			last_q <= req.last_index;
			rel_q <= {req.index[31], req.index} - {2'b00, range_offset_q};
			// Find-next starts one past the given index, so its start is formed here.
			if (req.kind == obe_pkg::KIND_FIND) begin
				sec_q <= {req.index[31], req.index} - {2'b00, range_offset_q} + 33'sd1;
			end else begin
				sec_q <= {req.last_index[31], req.last_index} - {2'b00, range_offset_q};
			end
		end

		if (state_q == S_CHK) begin
			res_flag_q <= (kind_q == obe_pkg::KIND_EMPTY);
			res_found_q <= '0;
			res_status_q <= 1'b0;
			hi_q <= rel_q[BW-1:0];
			lo_q <= rel_q[BW-1:0];
			wfirst_q <= rel_word;
			wlast_q <= rel_word;
			rd_ptr_q <= rel_word;
			unique case (kind_q) inside
				obe_pkg::KIND_SET, obe_pkg::KIND_CLEAR: begin
					res_status_q <= rel_out;
				end
				obe_pkg::KIND_TEST, obe_pkg::KIND_CLEAR_ALL: ;
				obe_pkg::KIND_RANGE: begin
					res_status_q <= !range_skip && (rel_q < 0 || sec_q > len33);
					wlast_q <= sec_word;
					hi_q <= sec_q[BW-1:0];
				end
				obe_pkg::KIND_FIND: begin
					wfirst_q <= sec_word;
					rd_ptr_q <= sec_word;
					lo_q <= sec_q[BW-1:0];
					wlast_q <= len_word;
					hi_q <= len_bit;
				end
				obe_pkg::KIND_FLIP, obe_pkg::KIND_EMPTY: begin
					wfirst_q <= '0;
					rd_ptr_q <= '0;
					lo_q <= '0;
					wlast_q <= len_word;
					hi_q <= len_bit;
				end
				default: ;
			endcase
		end

		if (state_q == S_LOOP) begin
			if (rd_more_q) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			ex_ptr_s1 <= rd_ptr_q;
			if (rd_vld_s1) begin
				case (kind_q) inside
					obe_pkg::KIND_SET, obe_pkg::KIND_CLEAR, obe_pkg::KIND_TEST: begin
						res_flag_q <= hit;
					end
					obe_pkg::KIND_FIND: begin
						if (hit) begin
							res_flag_q <= 1'b1;
							pos_q <= {ex_ptr_s1, enc};
						end
					end
					obe_pkg::KIND_EMPTY: begin
						if (hit) begin
							res_flag_q <= 1'b0;
						end
					end
					default: ;
				endcase
			end
		end

		if (state_q == S_ADD) begin
			res_found_q <= range_offset_q + OW'(pos_q);
		end

		if (rsp_load) begin
			out_flag_q <= res_flag_q;
			out_found_q <= res_found_q;
			out_status_q <= res_status_q;
		end
	end

endmodule

// ===== sim/obe_checker.sv =====
`timescale 1ns / 1ps

module bitset_mirror_check (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [obe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [obe_pkg::CFG_DATA_W-1:0] cfg_wdata,
	obe_req_if                             req,
	obe_rsp_if                             rsp,
	output int                             failures,
	output int                             outstanding,
	output int                             compared
);

	typedef struct packed {
		logic                         flag;
		logic [obe_pkg::OFFSET_W-1:0] found_index;
		logic                         status;
	} bit_answer_t;

	logic [4095:0]                  bit_mirror;
	logic [obe_pkg::OFFSET_W-1:0]   offset_reg;
	logic [obe_pkg::LENGTH_W-1:0]   length_reg;
	bit_answer_t                    pending_answers[$];

	// Applies one request to the mirrored set and returns the answer the block owes for it.
	function automatic bit_answer_t predict_bitset_op(obe_pkg::kind_t k,
			logic signed [obe_pkg::INDEX_W-1:0] first,
			logic signed [obe_pkg::INDEX_W-1:0] last_in);
		longint idx, last, off, len, rel, p;
		bit_answer_t a;
		idx  = first;
		last = last_in;
		off  = offset_reg;
		len  = length_reg;
		rel  = idx - off;
		a    = '0;
		case (k) inside
			obe_pkg::KIND_SET, obe_pkg::KIND_CLEAR: begin
				if (rel < 0 || rel > len) begin
					a.status = 1'b1;
				end else begin
					a.flag = bit_mirror[rel];
					bit_mirror[rel] = (k == obe_pkg::KIND_SET);
				end
			end
			obe_pkg::KIND_TEST: begin
				if (rel >= 0 && rel <= len)
					a.flag = bit_mirror[rel];
			end
			obe_pkg::KIND_RANGE: begin
				// A reversed range or a negative first index is silently dropped.
				if (idx <= last && idx >= 0) begin
					if (rel < 0 || last - off > len)
						a.status = 1'b1;
					else
						for (p = rel; p <= last - off; p++)
							bit_mirror[p] = 1'b1;
				end
			end
			obe_pkg::KIND_FIND: begin
				// The index is the start minus one, so rel may be -1 at the bottom.
				if (idx >= off - 1) begin
					for (p = rel + 1; p <= len && !a.flag; p++) begin
						if (bit_mirror[p]) begin
							a.flag = 1'b1;
							a.found_index = obe_pkg::OFFSET_W'(p + off);
						end
					end
				end
			end
			obe_pkg::KIND_CLEAR_ALL: begin
				bit_mirror = '0;
			end
			obe_pkg::KIND_FLIP: begin
				for (p = 0; p <= len; p++)
					bit_mirror[p] = ~bit_mirror[p];
			end
			default: begin
				a.flag = 1'b1;
				for (p = 0; p <= len && a.flag; p++)
					if (bit_mirror[p])
						a.flag = 1'b0;
			end
		endcase
		return a;
	endfunction

	task automatic report_field(string field, longint want, longint got);
		failures++;
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		bit_answer_t want;
		bit_answer_t got;
		if (!arst_n) begin
			bit_mirror = '0;
			offset_reg = '0;
			length_reg = 12'd4095;
			pending_answers.delete();
			failures = 0;
			compared = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == obe_pkg::CFG_OFFSET)
					offset_reg = cfg_wdata[obe_pkg::OFFSET_W-1:0];
				else
					length_reg = cfg_wdata[obe_pkg::LENGTH_W-1:0];
			end
			if (req.valid && req.ready)
				pending_answers.push_back(predict_bitset_op(req.kind, req.index, req.last_index));
			if (rsp.valid && rsp.ready) begin
				got = '{flag: rsp.flag, found_index: rsp.found_index, status: rsp.status};
				if (pending_answers.size() == 0) begin
					failures++;
					$display("%0t: unexpected result, expected none, got flag %0b index %0d status %0b",
						$time, got.flag, got.found_index, got.status);
				end else begin
					want = pending_answers.pop_front();
					compared++;
					if (got.flag !== want.flag)
						report_field("flag", want.flag, got.flag);
					if (got.found_index !== want.found_index)
						report_field("found_index", want.found_index, got.found_index);
					if (got.status !== want.status)
						report_field("status", want.status, got.status);
				end
			end
		end
		outstanding = pending_answers.size();
	end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	localparam int HOLD_CYCLES  = 400;
	localparam int QUIET_LIMIT  = 4000;
	localparam int PHASE_ITEMS  = 160;
	localparam int PHASES       = 10;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [obe_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [obe_pkg::CFG_DATA_W-1:0] cfg_wdata;

	obe_req_if req_ch ();
	obe_rsp_if rsp_ch ();

	int     mismatches;
	int     in_flight;
	int     checked;
	int     sent;
	int     settings;
	int     quiet_cycles;
	bit     calm;
	bit     hold_rsp;
	longint span_off;
	longint span_len;

	offset_bitset_engine u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	bitset_mirror_check u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.failures    (mismatches),
		.outstanding (in_flight),
		.compared    (checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Only called between phases, when no request is in flight.
	task automatic set_config(longint off, longint len);
		cfg_we    <= 1'b1;
		cfg_index <= obe_pkg::CFG_OFFSET;
		cfg_wdata <= off[obe_pkg::OFFSET_W-1:0];
		@(posedge clk);
		cfg_index <= obe_pkg::CFG_LENGTH;
		cfg_wdata <= {19'($urandom), len[obe_pkg::LENGTH_W-1:0]};
		@(posedge clk);
		cfg_we   <= 1'b0;
		span_off = off[obe_pkg::OFFSET_W-1:0];
		span_len = len[obe_pkg::LENGTH_W-1:0];
		settings++;
	endtask

	task automatic offer(obe_pkg::kind_t k, longint i, longint l);
		while (!calm && $urandom_range(0, 99) < 17) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.kind       <= k;
		req_ch.index      <= i[obe_pkg::INDEX_W-1:0];
		req_ch.last_index <= l[obe_pkg::INDEX_W-1:0];
		do @(posedge clk); while (!req_ch.ready);
		sent++;
	endtask

	// The count is read late, after the edge, so it never looks smaller than it is.
	task automatic settle();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (in_flight != 0);
	endtask

	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rsp = 1'b0;
			end
			rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 17);
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		obe_pkg::kind_t k;
		longint         i;
		longint         l;
		int             r;
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_index         <= obe_pkg::CFG_OFFSET;
		cfg_wdata         <= '0;
		req_ch.valid      <= 1'b0;
		req_ch.kind       <= obe_pkg::KIND_TEST;
		req_ch.index      <= '0;
		req_ch.last_index <= '0;
		calm     = 1'b0;
		hold_rsp = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Valid indexes 1000 to 1099.
		set_config(1000, 99);
		offer(obe_pkg::KIND_SET, 1000, 0);
		offer(obe_pkg::KIND_SET, 1000, -1);
		offer(obe_pkg::KIND_CLEAR, 1000, 0);
		offer(obe_pkg::KIND_SET, 999, 0);
		offer(obe_pkg::KIND_CLEAR, 1100, 0);
		offer(obe_pkg::KIND_TEST, 1100, 0);
		offer(obe_pkg::KIND_TEST, -1, 0);
		offer(obe_pkg::KIND_RANGE, 1010, 1020);
		offer(obe_pkg::KIND_RANGE, 1020, -1);
		offer(obe_pkg::KIND_RANGE, -1, 1050);
		offer(obe_pkg::KIND_RANGE, 990, 1005);
		offer(obe_pkg::KIND_RANGE, 1005, 2147483647);
		offer(obe_pkg::KIND_FIND, 998, 0);
		offer(obe_pkg::KIND_FIND, 999, 0);
		offer(obe_pkg::KIND_FIND, 1020, 0);
		offer(obe_pkg::KIND_EMPTY, 0, 0);
		offer(obe_pkg::KIND_FLIP, 0, 0);
		offer(obe_pkg::KIND_TEST, 1099, 0);
		offer(obe_pkg::KIND_CLEAR_ALL, 0, 0);
		offer(obe_pkg::KIND_EMPTY, 0, 0);
		offer(obe_pkg::KIND_TEST, longint'(32'sh8000_0000), 0);
		settle();

		// The set reaches past 2^31 - 1, so found indexes wrap around.
		set_config(2147483637, 4095);
		offer(obe_pkg::KIND_FLIP, 0, 0);
		offer(obe_pkg::KIND_FIND, 2147483646, 0);
		offer(obe_pkg::KIND_FIND, 2147483647, 0);
		offer(obe_pkg::KIND_CLEAR_ALL, 0, 0);
		settle();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: set_config(0, 4095);
				1: set_config(31'h7FFF_FFFF, 0);
				2: set_config(2147483632, 4095);
				3: set_config(5000, 63);
				4: set_config(123456789, 64);
				5: set_config(0, 0);
				6: set_config($urandom & 32'h7FFF_FFFF, $urandom_range(0, 4095));
				default: set_config($urandom_range(0, 100000), $urandom_range(0, 4095));
			endcase
			calm = (phase == 4);
			if (phase == 2)
				hold_rsp = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(0, 99);
				if (r < 25)
					k = obe_pkg::KIND_SET;
				else if (r < 40)
					k = obe_pkg::KIND_CLEAR;
				else if (r < 55)
					k = obe_pkg::KIND_TEST;
				else if (r < 65)
					k = obe_pkg::KIND_RANGE;
				else if (r < 82)
					k = obe_pkg::KIND_FIND;
				else if (r < 84)
					k = obe_pkg::KIND_CLEAR_ALL;
				else if (r < 89)
					k = obe_pkg::KIND_FLIP;
				else
					k = obe_pkg::KIND_EMPTY;
				case ($urandom_range(0, 9))
					0: i = $urandom;
					1: i = span_off + span_len + longint'($urandom_range(1, 3));
					2: i = span_off - longint'($urandom_range(1, 3));
					default: i = span_off + longint'($urandom_range(0, span_len));
				endcase
				case ($urandom_range(0, 6))
					0: l = $urandom;
					1: l = i - longint'($urandom_range(1, 5));
					2: l = span_off + span_len;
					default: l = i + longint'($urandom_range(0, 100));
				endcase
				offer(k, i, l);
			end
			settle();
		end
		calm = 1'b0;

		repeat (100) @(posedge clk);
		$display("Ran %0d requests, %0d results compared, across %0d offset and length settings.",
			sent, checked, settings);
		$display("Included offsets at both ends of the index space and a %0d-cycle response hold-off.",
			HOLD_CYCLES);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
